/* rtl/isa_atm_pkg.sv */
// Package for the ISA standard atmosphere block: sizes, fixed-point constants,
// pressure node tables built at elaboration, and the pipeline stage word.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package isa_atm_pkg;

    // interpolation segments per layer
    localparam int SEG = 64;

    // altitude limits in centimeters
    localparam int ALT_MAX_CM   = 2000000;
    localparam int TROPO_TOP_CM = 1100000;
    localparam int STRAT_SPAN_CM = 900000;

    // temperature in millikelvin
    localparam int T0_MK    = 288150;
    localparam int T_TOP_MK = 216650;

    // field widths
    localparam int ALT_IN_W = 24;
    localparam int ALT_W    = 21;
    localparam int TEMP_W   = 19;
    localparam int PRES_W   = 21;
    localparam int DENS_W   = 21;
    localparam int SND_W    = 17;

    // segment index and position widths
    localparam int IDX_W  = $clog2(SEG + 1);
    localparam int POS_W  = $clog2(TROPO_TOP_CM * SEG + 1);
    localparam int SPAN_W = 21;
    localparam int R_W    = SPAN_W + 1;

    // reciprocal of the layer span, position * recip >> 48 gives the index
    localparam int SPAN_SHIFT = 48;
    localparam int RECIP_W    = 29;
    localparam longint unsigned RECIP_TROPO = (64'd1 << SPAN_SHIFT) / 64'd1100000;
    localparam longint unsigned RECIP_STRAT = (64'd1 << SPAN_SHIFT) / 64'd900000;
    localparam int IPROD_W = POS_W + RECIP_W;

    // temperature lapse: (65h+500)/1000 through a reciprocal
    localparam int TNUM_W  = 27;
    localparam int TPROD_W = 55;
    localparam int TDIV_SHIFT = 37;
    localparam longint unsigned RECIP_1000 = 64'd137438954;

    // speed of sound radicand: t*105347 + floor(t*2529/3125)
    localparam int SX_W     = 35;
    localparam int SRES_W   = 36;
    localparam int FNUM_W   = 30;
    localparam int FPROD_W  = 61;
    localparam int FDIV_SHIFT = 42;
    localparam longint unsigned RECIP_3125 = 64'd1407374884;
    localparam int SND_INT  = 105347;
    localparam int SND_FRAC = 2529;
    localparam int SQRT_STEPS = 18;

    // density: (p*100000*65536 + den/2) / (28705*t)
    localparam int DEN_W  = 33;
    localparam int PMUL_W = 38;
    localparam int RN_W   = 55;
    localparam int GAS_R  = 28705;
    localparam int P_SCALE = 100000;

    // interpolation numerator
    localparam int NUM_W = 42;
    localparam int DIV_BITS = 21;

    // pipeline stage numbers
    localparam int ST_CLAMP = 0;
    localparam int ST_POS   = 1;
    localparam int ST_MUL   = 2;
    localparam int ST_IDX   = 3;
    localparam int ST_REM   = 4;
    localparam int ST_FIX   = 5;
    localparam int ST_LOOK  = 6;
    localparam int ST_DIFF  = 7;
    localparam int ST_SQ0   = ST_DIFF;
    localparam int ST_SQN   = ST_SQ0 + (SQRT_STEPS / 2) - 1;
    localparam int ST_ID0   = ST_DIFF + 1;
    localparam int ST_IDN   = ST_ID0 + (DIV_BITS + 1) / 2 - 1;
    localparam int ST_PRES  = ST_IDN + 1;
    localparam int ST_PMUL  = ST_PRES + 1;
    localparam int ST_RNUM  = ST_PMUL + 1;
    localparam int ST_RD0   = ST_RNUM + 1;
    localparam int ST_RDN   = ST_RD0 + (DIV_BITS + 1) / 2 - 1;
    localparam int NUM_ST   = ST_RDN + 1;

    typedef logic [PRES_W-1:0] node_t;
    typedef node_t node_table_t [0:SEG];

    // one word carried down the pipeline
    typedef struct packed {
        logic [ALT_W-1:0]   h;
        logic               strat;
        logic [POS_W-1:0]   pos;
        logic [TNUM_W-1:0]  tnum;
        logic [IPROD_W-1:0] iprod;
        logic [TPROD_W-1:0] tprod;
        logic [IDX_W-1:0]   idx;
        logic [TEMP_W-1:0]  t;
        logic [R_W-1:0]     r;
        logic [DEN_W-1:0]   den;
        logic [SX_W-1:0]    t40;
        logic [FNUM_W-1:0]  fnum;
        logic [FPROD_W-1:0] fprod;
        logic               top;
        logic [PRES_W-1:0]  lo;
        logic [PRES_W-1:0]  hi;
        logic [SX_W-1:0]    sx;
        logic [SRES_W-1:0]  sres;
        logic               neg;
        logic [NUM_W-1:0]   num;
        logic [PRES_W-1:0]  dq;
        logic [PRES_W-1:0]  p;
        logic [SND_W-1:0]   snd;
        logic [PMUL_W-1:0]  pmul;
        logic [RN_W-1:0]    rn;
        logic               sat;
        logic [DENS_W-1:0]  rq;
    } stage_t;

    // shift-subtract divide for table building
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        logic [64:0] rem;
        longint unsigned q;
        rem = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // quotient with 28 fraction bits
    function automatic longint unsigned div_q28(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = udiv64(num, den);
        r = num - q * den;
        for (int i = 0; i < 28; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // exp(-a) in Q28 as 2^56 / exp(a)
    function automatic longint unsigned exp_neg_q28(input longint unsigned a);
        longint unsigned sum;
        longint unsigned term;
        sum = 64'd1 << 28;
        term = 64'd1 << 28;
        for (int j = 1; j <= 64; j++) begin
            if (term != 0) begin
                term = udiv64((term * a) >> 28, longint'(j));
                sum = sum + term;
            end
        end
        return udiv64((64'd1 << 56) + (sum >> 1), sum);
    endfunction

    // 2*atanh(w) series
    function automatic longint unsigned neg_ln_q28(input longint unsigned w);
        longint unsigned w2;
        longint unsigned p;
        longint unsigned s;
        longint unsigned j;
        w2 = (w * w) >> 28;
        p = w;
        s = '0;
        j = 64'd1;
        while (p != 0) begin
            s = s + udiv64(p, j);
            p = (p * w2) >> 28;
            j = j + 64'd2;
        end
        return s << 1;
    endfunction

    function automatic longint unsigned tropo_node(input longint unsigned k);
        longint unsigned w;
        longint unsigned a;
        longint unsigned e;
        w = div_q28(64'd71500 * k, 64'd576300 * longint'(SEG) - 64'd71500 * k);
        a = udiv64(neg_ln_q28(w) * 64'd9806650, 64'd1865825);
        e = exp_neg_q28(a);
        return (64'd1621200 * e + (64'd1 << 27)) >> 28;
    endfunction

    function automatic node_table_t build_tropo();
        node_table_t tab;
        for (int k = 0; k <= SEG; k++) begin
            tab[k] = PRES_W'(tropo_node(longint'(k)));
        end
        return tab;
    endfunction

    function automatic node_table_t build_strat();
        node_table_t tab;
        longint unsigned ptop;
        longint unsigned a;
        longint unsigned e;
        ptop = tropo_node(longint'(SEG));
        for (int k = 0; k <= SEG; k++) begin
            a = div_q28(64'd882598500 * longint'(k), longint'(SEG) * 64'd621893825);
            e = exp_neg_q28(a);
            tab[k] = PRES_W'((ptop * e + (64'd1 << 27)) >> 28);
        end
        return tab;
    endfunction

    localparam node_table_t TROPO_NODES = build_tropo();
    localparam node_table_t STRAT_NODES = build_strat();

endpackage

`default_nettype wire

/* rtl/isa_atm_if.sv */
// Stream interfaces for the ISA atmosphere block: altitude words in,
// property words out. Depends on isa_atm_pkg for field widths.
`default_nettype none

interface isa_atm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [isa_atm_pkg::ALT_IN_W-1:0] altitude_cm;

    modport source (output valid, output altitude_cm, input ready);
    modport sink   (input valid, input altitude_cm, output ready);
endinterface

interface isa_atm_out_if;
    logic                              valid;
    logic                              ready;
    logic [isa_atm_pkg::ALT_W-1:0]     clamped_altitude_cm;
    logic [isa_atm_pkg::TEMP_W-1:0]    temperature_mk;
    logic [isa_atm_pkg::PRES_W-1:0]    pressure_q4;
    logic [isa_atm_pkg::DENS_W-1:0]    density_q20;
    logic [isa_atm_pkg::SND_W-1:0]     sound_speed_q8;

    modport source (output valid, output clamped_altitude_cm, output temperature_mk,
                    output pressure_q4, output density_q20, output sound_speed_q8,
                    input ready);
    modport sink   (input valid, input clamped_altitude_cm, input temperature_mk,
                    input pressure_q4, input density_q20, input sound_speed_q8,
                    output ready);
endinterface

`default_nettype wire

/* rtl/isa_atmosphere_properties.sv */
// ISA standard atmosphere 0..20 km: pipelined temperature, pressure,
// density and speed of sound. Depends on isa_atm_pkg and isa_atm_if.
//
// Usage:
//   sample carries one signed altitude word in centimeters; result carries
//   the clamped altitude, temperature (mK), pressure (1/16 Pa), density
//   (2^-20 kg/m3) and speed of sound (1/256 m/s) for that word.
//   Both channels move a word when valid and ready are high at a clock edge.
// Throughput: one word per cycle while result is ready.
// Depth: the pipeline depth is set by the shift-subtract stages of the
//   interpolation divide and the density divide, two quotient bits per
//   stage, one after the other.
// Stall: each stage holds its word while the stage after it is full and
//   stalled; empty stages still fill, so the pipe packs up before sample
//   ready drops. Nothing is dropped or repeated.
// Reset: rst_n clears all stage valid bits; the pressure tables are
//   constants, so the block takes words from the first cycle after reset.
`default_nettype none

module isa_atmosphere_properties (
    input  wire logic       clk,
    input  wire logic       rst_n,
    isa_atm_in_if.sink      sample,
    isa_atm_out_if.source   result
);

    localparam int LAST = isa_atm_pkg::NUM_ST - 1;

    isa_atm_pkg::stage_t pipe_reg  [0:LAST];
    isa_atm_pkg::stage_t pipe_next [0:LAST];
    logic [LAST:0] valid_reg;
    logic [LAST:0] valid_next;
    logic [LAST:0] en;

    // span of the layer
    function automatic logic [isa_atm_pkg::SPAN_W-1:0] span_of(input logic strat);
        return strat ? isa_atm_pkg::SPAN_W'(isa_atm_pkg::STRAT_SPAN_CM)
                     : isa_atm_pkg::SPAN_W'(isa_atm_pkg::TROPO_TOP_CM);
    endfunction

    // work done by stage k on the word from stage k-1
    function automatic isa_atm_pkg::stage_t stage_step(input int k,
                                                       input isa_atm_pkg::stage_t s_in);
        isa_atm_pkg::stage_t s;
        logic [isa_atm_pkg::SPAN_W-1:0]   span;
        logic [isa_atm_pkg::ALT_W-1:0]    off;
        logic [isa_atm_pkg::RECIP_W-1:0]  recip;
        logic [isa_atm_pkg::IDX_W-1:0]    i0;
        logic [isa_atm_pkg::IDX_W-1:0]    i1;
        logic [isa_atm_pkg::PRES_W-1:0]   diff;
        logic [isa_atm_pkg::SRES_W-1:0]   sbit;
        logic [isa_atm_pkg::SRES_W-1:0]   ssum;
        logic [isa_atm_pkg::NUM_W-1:0]    dsub;
        logic [isa_atm_pkg::RN_W-1:0]     rsub;
        int b;
        int j;
        s = s_in;
        span = span_of(s_in.strat);

        // layer offset and lapse numerator
        if (k == isa_atm_pkg::ST_POS) begin
            s.strat = (s.h > isa_atm_pkg::ALT_W'(isa_atm_pkg::TROPO_TOP_CM));
            off = s.strat ? s.h - isa_atm_pkg::ALT_W'(isa_atm_pkg::TROPO_TOP_CM) : s.h;
            s.pos = isa_atm_pkg::POS_W'(32'(off) * 32'(isa_atm_pkg::SEG));
            s.tnum = isa_atm_pkg::TNUM_W'(s.h) * isa_atm_pkg::TNUM_W'(65)
                   + isa_atm_pkg::TNUM_W'(500);
        end

        // reciprocal products
        if (k == isa_atm_pkg::ST_MUL) begin
            recip = s.strat ? isa_atm_pkg::RECIP_W'(isa_atm_pkg::RECIP_STRAT)
                            : isa_atm_pkg::RECIP_W'(isa_atm_pkg::RECIP_TROPO);
            s.iprod = isa_atm_pkg::IPROD_W'(s.pos) * isa_atm_pkg::IPROD_W'(recip);
            s.tprod = isa_atm_pkg::TPROD_W'(s.tnum)
                    * isa_atm_pkg::TPROD_W'(isa_atm_pkg::RECIP_1000);
        end

        // segment estimate and temperature
        if (k == isa_atm_pkg::ST_IDX) begin
            s.idx = isa_atm_pkg::IDX_W'(s.iprod >> isa_atm_pkg::SPAN_SHIFT);
            s.t = s.strat ? isa_atm_pkg::TEMP_W'(isa_atm_pkg::T_TOP_MK)
                : isa_atm_pkg::TEMP_W'(isa_atm_pkg::T0_MK)
                  - isa_atm_pkg::TEMP_W'(s.tprod >> isa_atm_pkg::TDIV_SHIFT);
        end

        // remainder, density divisor, sound radicand parts
        if (k == isa_atm_pkg::ST_REM) begin
            s.r = isa_atm_pkg::R_W'(s.pos - isa_atm_pkg::POS_W'(s.idx)
                                    * isa_atm_pkg::POS_W'(span));
            s.den = isa_atm_pkg::DEN_W'(s.t) * isa_atm_pkg::DEN_W'(isa_atm_pkg::GAS_R);
            s.t40 = isa_atm_pkg::SX_W'(s.t) * isa_atm_pkg::SX_W'(isa_atm_pkg::SND_INT);
            s.fnum = isa_atm_pkg::FNUM_W'(s.t) * isa_atm_pkg::FNUM_W'(isa_atm_pkg::SND_FRAC);
        end

        // index correction
        if (k == isa_atm_pkg::ST_FIX) begin
            if (s.r >= isa_atm_pkg::R_W'(span)) begin
                s.idx = s.idx + isa_atm_pkg::IDX_W'(1);
                s.r = s.r - isa_atm_pkg::R_W'(span);
            end
            s.fprod = isa_atm_pkg::FPROD_W'(s.fnum)
                    * isa_atm_pkg::FPROD_W'(isa_atm_pkg::RECIP_3125);
        end

        // node lookup
        if (k == isa_atm_pkg::ST_LOOK) begin
            s.top = (s.idx >= isa_atm_pkg::IDX_W'(isa_atm_pkg::SEG));
            i0 = s.top ? isa_atm_pkg::IDX_W'(isa_atm_pkg::SEG) : s.idx;
            i1 = s.top ? isa_atm_pkg::IDX_W'(isa_atm_pkg::SEG)
                       : s.idx + isa_atm_pkg::IDX_W'(1);
            s.lo = s.strat ? isa_atm_pkg::STRAT_NODES[i0] : isa_atm_pkg::TROPO_NODES[i0];
            s.hi = s.strat ? isa_atm_pkg::STRAT_NODES[i1] : isa_atm_pkg::TROPO_NODES[i1];
            s.sx = s.t40 + isa_atm_pkg::SX_W'(s.fprod >> isa_atm_pkg::FDIV_SHIFT);
            s.sres = '0;
        end

        // interpolation numerator
        if (k == isa_atm_pkg::ST_DIFF) begin
            s.neg = (s.lo >= s.hi);
            diff = s.neg ? s.lo - s.hi : s.hi - s.lo;
            s.num = isa_atm_pkg::NUM_W'(diff) * isa_atm_pkg::NUM_W'(s.r)
                  + isa_atm_pkg::NUM_W'(span >> 1);
            s.dq = '0;
        end

        // square root, two result bits per stage
        if (k >= isa_atm_pkg::ST_SQ0 && k <= isa_atm_pkg::ST_SQN) begin
            for (int n = 0; n < 2; n++) begin
                j = 2 * (k - isa_atm_pkg::ST_SQ0) + n;
                sbit = isa_atm_pkg::SRES_W'(1) << (2 * (isa_atm_pkg::SQRT_STEPS - 1 - j));
                ssum = s.sres + sbit;
                if (isa_atm_pkg::SRES_W'(s.sx) >= ssum) begin
                    s.sx = isa_atm_pkg::SX_W'(isa_atm_pkg::SRES_W'(s.sx) - ssum);
                    s.sres = (s.sres >> 1) + sbit;
                end else begin
                    s.sres = s.sres >> 1;
                end
            end
        end

        // interpolation divide by the span, two quotient bits per stage
        if (k >= isa_atm_pkg::ST_ID0 && k <= isa_atm_pkg::ST_IDN) begin
            for (int n = 0; n < 2; n++) begin
                b = isa_atm_pkg::DIV_BITS - 1 - 2 * (k - isa_atm_pkg::ST_ID0) - n;
                if (b >= 0) begin
                    dsub = isa_atm_pkg::NUM_W'(span) << b;
                    if (s.num >= dsub) begin
                        s.num = s.num - dsub;
                        s.dq[b] = 1'b1;
                    end
                end
            end
        end

        // pressure and speed of sound
        if (k == isa_atm_pkg::ST_PRES) begin
            s.p = s.top ? s.lo : (s.neg ? s.lo - s.dq : s.lo + s.dq);
            s.snd = isa_atm_pkg::SND_W'((s.sres + isa_atm_pkg::SRES_W'(1)) >> 1);
        end

        if (k == isa_atm_pkg::ST_PMUL) begin
            s.pmul = isa_atm_pkg::PMUL_W'(s.p) * isa_atm_pkg::PMUL_W'(isa_atm_pkg::P_SCALE);
        end

        // density numerator and saturation check
        if (k == isa_atm_pkg::ST_RNUM) begin
            s.rn = (isa_atm_pkg::RN_W'(s.pmul) << 16) + isa_atm_pkg::RN_W'(s.den >> 1);
            s.sat = (s.rn >= (isa_atm_pkg::RN_W'(s.den) << isa_atm_pkg::DIV_BITS));
            s.rq = '0;
        end

        // density divide, two quotient bits per stage
        if (k >= isa_atm_pkg::ST_RD0 && k <= isa_atm_pkg::ST_RDN) begin
            for (int n = 0; n < 2; n++) begin
                b = isa_atm_pkg::DIV_BITS - 1 - 2 * (k - isa_atm_pkg::ST_RD0) - n;
                if (b >= 0) begin
                    rsub = isa_atm_pkg::RN_W'(s.den) << b;
                    if (s.rn >= rsub) begin
                        s.rn = s.rn - rsub;
                        s.rq[b] = 1'b1;
                    end
                end
            end
            if (k == isa_atm_pkg::ST_RDN && s.sat) begin
                s.rq = '1;
            end
        end

        return s;
    endfunction

    // clamp the incoming altitude
    always_comb
    begin
        pipe_next[0] = '0;
        if (sample.altitude_cm[isa_atm_pkg::ALT_IN_W-1]) begin
            pipe_next[0].h = '0;
        end else if (sample.altitude_cm
                     > isa_atm_pkg::ALT_IN_W'(isa_atm_pkg::ALT_MAX_CM)) begin
            pipe_next[0].h = isa_atm_pkg::ALT_W'(isa_atm_pkg::ALT_MAX_CM);
        end else begin
            pipe_next[0].h = isa_atm_pkg::ALT_W'(sample.altitude_cm);
        end
    end

    // stage logic
    for (genvar k = 1; k <= LAST; k++) begin : g_stage
        always_comb
        begin
            pipe_next[k] = stage_step(k, pipe_reg[k-1]);
        end
    end

    // load enables: a stage loads when empty or when the next one moves
    always_comb
    begin
        en[LAST] = !valid_reg[LAST] || result.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0]) begin
            valid_next[0] = sample.valid;
        end
        for (int k = 1; k <= LAST; k++) begin
            if (en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // stage words
    for (genvar k = 0; k <= LAST; k++) begin : g_word
        always_ff @(posedge clk)
        begin
            if (en[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign sample.ready = en[0];

    assign result.valid               = valid_reg[LAST];
    assign result.clamped_altitude_cm = pipe_reg[LAST].h;
    assign result.temperature_mk      = pipe_reg[LAST].t;
    assign result.pressure_q4         = pipe_reg[LAST].p;
    assign result.density_q20         = pipe_reg[LAST].rq;
    assign result.sound_speed_q8      = pipe_reg[LAST].snd;

endmodule

`default_nettype wire

/* rtl/isa_atm_checker.sv */
// Port-level checks for isa_atmosphere_properties, attached by bind.
// Depends on isa_atm_pkg for limits and field widths.
`default_nettype none

module isa_atm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [isa_atm_pkg::ALT_W-1:0]     clamped_altitude_cm,
    input wire logic [isa_atm_pkg::TEMP_W-1:0]    temperature_mk,
    input wire logic [isa_atm_pkg::SND_W-1:0]     sound_speed_q8
);

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(temperature_mk)
                                    && $stable(clamped_altitude_cm))
        else $error("result word changed while stalled");

    // clamp range
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> clamped_altitude_cm <= isa_atm_pkg::ALT_W'(isa_atm_pkg::ALT_MAX_CM))
        else $error("altitude beyond clamp");

    // isothermal layer above the tropopause
    a_strat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped_altitude_cm > isa_atm_pkg::ALT_W'(isa_atm_pkg::TROPO_TOP_CM)
        |-> temperature_mk == isa_atm_pkg::TEMP_W'(isa_atm_pkg::T_TOP_MK))
        else $error("stratosphere temperature wrong");

    // temperature band and nonzero sound speed
    a_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temperature_mk >= isa_atm_pkg::TEMP_W'(isa_atm_pkg::T_TOP_MK)
                      && temperature_mk <= isa_atm_pkg::TEMP_W'(isa_atm_pkg::T0_MK)
                      && sound_speed_q8 != '0)
        else $error("temperature or sound speed out of range");

    // nothing comes out while in reset
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind isa_atmosphere_properties isa_atm_checker u_isa_atm_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (result.valid),
    .out_ready           (result.ready),
    .clamped_altitude_cm (result.clamped_altitude_cm),
    .temperature_mk      (result.temperature_mk),
    .sound_speed_q8      (result.sound_speed_q8)
);

`default_nettype wire
